@@ sv/frd_pkg.sv @@
// shared types, codes and helpers of the fastcgi record deframer
// no dependencies; used by frd_parser, frd_fifo and the core top level
package frd_pkg;

	// event codes on event_kind
	localparam logic [2:0] EV_CONTENT = 3'd0;
	localparam logic [2:0] EV_BEGIN   = 3'd1;
	localparam logic [2:0] EV_ABORT   = 3'd2;
	localparam logic [2:0] EV_PARAMS  = 3'd3;
	localparam logic [2:0] EV_STDIN   = 3'd4;
	localparam logic [2:0] EV_OTHER   = 3'd5;
	localparam logic [2:0] EV_CLOSED  = 3'd6;

	// record type codes
	localparam logic [7:0] T_BEGIN  = 8'd1;
	localparam logic [7:0] T_ABORT  = 8'd2;
	localparam logic [7:0] T_PARAMS = 8'd4;
	localparam logic [7:0] T_STDIN  = 8'd5;

	// parser phases
	localparam logic [1:0] PH_HDR  = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_PAD  = 2'd2;

	localparam logic [2:0] HDR_LAST_IDX = 3'd7;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  payload_byte;
		logic [7:0]  record_type;
		logic [15:0] request_ident;
		logic [7:0]  proto_version;
		logic [15:0] body_length;
		logic [15:0] app_role;
		logic [7:0]  conn_flags;
		logic        last;
	} result_t;

	// record-end event for a header; EV_CONTENT means no event
	function automatic logic [2:0] end_kind(input logic [7:0] rtype, input logic [15:0] blen);
		logic [2:0] k;
		begin
			case (rtype)
				T_BEGIN:  k = EV_BEGIN;
				T_ABORT:  k = EV_ABORT;
				T_PARAMS: k = (blen == 16'd0) ? EV_PARAMS : EV_CONTENT;
				T_STDIN:  k = (blen == 16'd0) ? EV_STDIN : EV_CONTENT;
				default:  k = EV_OTHER;
			endcase
			return k;
		end
	endfunction

	function automatic result_t mk_result(
		input logic [2:0]  kind,
		input logic [7:0]  payload,
		input logic [7:0]  rtype,
		input logic [15:0] req,
		input logic [7:0]  ver,
		input logic [15:0] blen,
		input logic [15:0] role,
		input logic [7:0]  flags
	);
		result_t r;
		begin
			r.event_kind    = kind;
			r.payload_byte  = payload;
			r.record_type   = rtype;
			r.request_ident = req;
			r.proto_version = ver;
			r.body_length   = blen;
			r.app_role      = (kind == EV_BEGIN) ? role : 16'd0;
			r.conn_flags    = (kind == EV_BEGIN) ? flags : 8'd0;
			r.last          = 1'b0;
			return r;
		end
	endfunction

endpackage

@@ sv/fastcgi_record_deframer_core.sv @@
// top level of the fastcgi record deframer: byte input, record event output
// depends on frd_pkg, frd_parser and frd_fifo
//
// One stream byte is taken per cycle while in_ready is high and goes straight
// through the parser in the cycle it is accepted; the results it causes (none,
// one, or two when the last content byte also ends the record) are written
// into a result queue of FIFO_DEPTH entries that drives the output ports.
// in_ready is high while the queue has room for two results, so the input runs
// at one byte per cycle whenever the output side takes one result per cycle; a
// byte that yields two results fills two queue entries. Results are registered
// in the queue before they reach the output. link_error drops the byte, clears
// the parser and produces a closed event.
module fastcgi_record_deframer_core #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        link_error,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  record_type,
	output logic [15:0] request_ident,
	output logic [7:0]  proto_version,
	output logic [15:0] body_length,
	output logic [15:0] app_role,
	output logic [7:0]  conn_flags,
	output logic        last
);

	frd_pkg::result_t res0, res1, head;
	logic [1:0]       res_cnt;
	logic             acc;
	logic             room2;

	assign in_ready = room2;
	assign acc      = in_valid && in_ready;

	frd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.data_byte  (data_byte),
		.link_error (link_error),
		.res0       (res0),
		.res1       (res1),
		.res_cnt    (res_cnt)
	);

	frd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (res_cnt),
		.d0        (res0),
		.d1        (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.q         (head)
	);

	assign event_kind    = head.event_kind;
	assign payload_byte  = head.payload_byte;
	assign record_type   = head.record_type;
	assign request_ident = head.request_ident;
	assign proto_version = head.proto_version;
	assign body_length   = head.body_length;
	assign app_role      = head.app_role;
	assign conn_flags    = head.conn_flags;
	assign last          = head.last;

`ifndef NO_ASSERTIONS
	a_ready_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input stalled with empty queue");
	a_closed_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == frd_pkg::EV_CLOSED |-> body_length == 16'd0
			&& record_type == 8'd0 && last) else $error("closed event carries fields");
	a_role_only_begin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != frd_pkg::EV_BEGIN |-> app_role == 16'd0
			&& conn_flags == 8'd0) else $error("role outside begin event");
`endif

endmodule

@@ sv/frd_parser.sv @@
// byte-wise record parser: header collection, content pass-through, padding skip
// depends on frd_pkg; produces up to two results per accepted byte
module frd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        data_byte,
	input  logic              link_error,
	output frd_pkg::result_t  res0,
	output frd_pkg::result_t  res1,
	output logic [1:0]        res_cnt
);

	logic [1:0]  phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  ver_q, ver_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] req_q, req_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  pad_q, pad_d;
	logic [15:0] role_q, role_d;
	logic [7:0]  flags_q, flags_d;
	logic [2:0]  idx;
	logic [2:0]  kind;
	logic [1:0]  n;

	assign idx = cnt_q[2:0];

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		ver_d   = ver_q;
		type_d  = type_q;
		req_d   = req_q;
		len_d   = len_q;
		pad_d   = pad_q;
		role_d  = role_q;
		flags_d = flags_q;
		res0    = '0;
		res1    = '0;
		n       = 2'd0;
		kind    = frd_pkg::EV_CONTENT;
		if (link_error) begin
			phase_d = frd_pkg::PH_HDR;
			cnt_d   = 16'd0;
			ver_d   = 8'd0;
			type_d  = 8'd0;
			req_d   = 16'd0;
			len_d   = 16'd0;
			pad_d   = 8'd0;
			role_d  = 16'd0;
			flags_d = 8'd0;
			res0.event_kind = frd_pkg::EV_CLOSED;
			n = 2'd1;
		end else begin
			case (phase_q)
				frd_pkg::PH_BODY: begin
					// begin-request body: role high, role low, flags
					if (type_q == frd_pkg::T_BEGIN) begin
						if (cnt_q == 16'd0)
							role_d = {data_byte, role_q[7:0]};
						else if (cnt_q == 16'd1)
							role_d = {role_q[15:8], data_byte};
						else if (cnt_q == 16'd2)
							flags_d = data_byte;
					end
					res0 = frd_pkg::mk_result(frd_pkg::EV_CONTENT, data_byte, type_q, req_q,
						ver_q, len_q, role_d, flags_d);
					n = 2'd1;
					cnt_d = cnt_q + 16'd1;
					if (cnt_d >= len_q) begin
						cnt_d = 16'd0;
						if (pad_q != 8'd0) begin
							phase_d = frd_pkg::PH_PAD;
						end else begin
							phase_d = frd_pkg::PH_HDR;
							kind = frd_pkg::end_kind(type_q, len_q);
							if (kind != frd_pkg::EV_CONTENT) begin
								res1 = frd_pkg::mk_result(kind, 8'd0, type_q, req_q, ver_q,
									len_q, role_d, flags_d);
								n = 2'd2;
							end
						end
					end
				end
				frd_pkg::PH_PAD: begin
					cnt_d = cnt_q + 16'd1;
					if (cnt_d >= {8'd0, pad_q}) begin
						cnt_d   = 16'd0;
						phase_d = frd_pkg::PH_HDR;
						kind = frd_pkg::end_kind(type_q, len_q);
						if (kind != frd_pkg::EV_CONTENT) begin
							res0 = frd_pkg::mk_result(kind, 8'd0, type_q, req_q, ver_q,
								len_q, role_q, flags_q);
							n = 2'd1;
						end
					end
				end
				default: begin
					// header collection; the unused phase code acts the same
					case (idx)
						3'd0: ver_d  = data_byte;
						3'd1: type_d = data_byte;
						3'd2: req_d  = {data_byte, req_q[7:0]};
						3'd3: req_d  = {req_q[15:8], data_byte};
						3'd4: len_d  = {data_byte, len_q[7:0]};
						3'd5: len_d  = {len_q[15:8], data_byte};
						3'd6: pad_d  = data_byte;
						default: ;
					endcase
					phase_d = frd_pkg::PH_HDR;
					cnt_d = 16'(idx) + 16'd1;
					if (idx == frd_pkg::HDR_LAST_IDX) begin
						cnt_d   = 16'd0;
						role_d  = 16'd0;
						flags_d = 8'd0;
						if (len_d != 16'd0) begin
							phase_d = frd_pkg::PH_BODY;
						end else if (pad_d != 8'd0) begin
							phase_d = frd_pkg::PH_PAD;
						end else begin
							kind = frd_pkg::end_kind(type_d, len_d);
							res0 = frd_pkg::mk_result(kind, 8'd0, type_d, req_d, ver_d,
								len_d, 16'd0, 8'd0);
							n = 2'd1;
						end
					end
				end
			endcase
		end
		if (n == 2'd1)
			res0.last = 1'b1;
		else if (n == 2'd2)
			res1.last = 1'b1;
	end

	assign res_cnt = acc ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= frd_pkg::PH_HDR;
			cnt_q   <= 16'd0;
			ver_q   <= 8'd0;
			type_q  <= 8'd0;
			req_q   <= 16'd0;
			len_q   <= 16'd0;
			pad_q   <= 8'd0;
			role_q  <= 16'd0;
			flags_q <= 8'd0;
		end else if (acc) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			ver_q   <= ver_d;
			type_q  <= type_d;
			req_q   <= req_d;
			len_q   <= len_d;
			pad_q   <= pad_d;
			role_q  <= role_d;
			flags_q <= flags_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_phase3: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("parser entered unused phase");
	a_body_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == frd_pkg::PH_BODY |-> cnt_q < len_q)
		else $error("content count passed content length");
	a_pad_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == frd_pkg::PH_PAD |-> cnt_q < {8'd0, pad_q})
		else $error("padding count passed padding length");
	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == frd_pkg::PH_HDR |-> cnt_q < 16'd8)
		else $error("header count out of range");
	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && link_error |=> phase_q == frd_pkg::PH_HDR && cnt_q == 16'd0 && len_q == 16'd0)
		else $error("link error did not return parser to idle");
`endif

endmodule

@@ sv/frd_fifo.sv @@
// small result queue taking up to two results per cycle and giving one while out_ready is high
// depends on frd_pkg for the result struct
module frd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  frd_pkg::result_t  d0,
	input  frd_pkg::result_t  d1,
	output logic              room2,
	output logic              out_valid,
	input  logic              out_ready,
	output frd_pkg::result_t  q
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM2_MAX = CW'(DEPTH - 2);

	frd_pkg::result_t mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr1, wr2, rd_nx;
	logic [CW-1:0] count_q;
	logic          pop;

	assign wr1   = (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
	assign wr2   = (wr1 == LAST_PTR) ? '0 : wr1 + PW'(1);
	assign rd_nx = (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign room2     = count_q <= ROOM2_MAX;
	assign q         = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wr_q] <= d0;
		if (push_n == 2'd2)
			mem[wr1] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push_n)
				2'd1:    wr_q <= wr1;
				2'd2:    wr_q <= wr2;
				default: wr_q <= wr_q;
			endcase
			if (pop)
				rd_q <= rd_nx;
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> count_q <= ROOM2_MAX)
		else $error("push into a queue without room");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count above depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd0 && !pop |=> $stable(count_q))
		else $error("queue count moved without push or pop");
`endif

endmodule
